### hdl/ffa_pkg.sv
package ffa_pkg;

    // Heap geometry
    localparam int HEAP_BYTES   = 65536;
    localparam int ALIGN_BYTES  = 8;
    localparam int HEADER_BYTES = 8;
    localparam int SLOT_COUNT   = HEAP_BYTES / ALIGN_BYTES;
    localparam int ALIGN_SH     = $clog2(ALIGN_BYTES);
    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int STEP_W       = SLOT_W + 1;

    // Field widths
    localparam int ADDR_W   = 16;
    localparam int SIZE_W   = 16;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 4;
    localparam int STAT_W   = 2;

    // Port widths
    localparam int S_TDATA_W = SIZE_W + ADDR_W;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = ADDR_W;
    localparam int M_TUSER_W = STAT_W + 1;

    // Opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH      = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [CFG_W-1:0] HEAP_LIMIT_RST = CFG_W'(65536);
    localparam logic [CFG_W-1:0] BATCH_RST      = CFG_W'(4096);

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OOM       = 2'd1,
        STAT_ZERO_SIZE = 2'd2,
        STAT_NULL_FREE = 2'd3
    } status_t;

    // One entry of the link store
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] next;
    } link_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic walk_start;
        logic rd_issue;
        logic walk_adv;
        logic unlink;
        logic calc_need;
        logic calc_fit;
        logic calc_grow;
        logic commit;
        logic do_free;
        logic res_zero;
        logic res_null;
        logic push;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_free;
        logic size_zero;
        logic addr_zero;
        logic cur_ok;
        logic steps_done;
        logic fit;
    } sts_t;

endpackage

### hdl/ffa_ctrl.sv
module ffa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output ffa_pkg::cmd_t  cmd,
    input  ffa_pkg::sts_t  sts
);
    import ffa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WALK_TEST,
        S_WALK_CHK,
        S_NEED,
        S_FIT,
        S_GROW,
        S_COMMIT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    // Sequencing
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_DONE;
                if (sts.is_free) begin
                    if (sts.addr_zero) begin
                        cmd.res_null = 1'b1;
                    end else begin
                        cmd.do_free = 1'b1;
                    end
                end else if (sts.size_zero) begin
                    cmd.res_zero = 1'b1;
                end else begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK_TEST;
                end
            end
            S_WALK_TEST: begin
                if (sts.cur_ok && !sts.steps_done) begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_WALK_CHK;
                end else begin
                    state_next = S_NEED;
                end
            end
            S_WALK_CHK: begin
                if (sts.fit) begin
                    cmd.unlink = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.walk_adv = 1'b1;
                    state_next   = S_WALK_TEST;
                end
            end
            S_NEED: begin
                cmd.calc_need = 1'b1;
                state_next    = S_FIT;
            end
            S_FIT: begin
                cmd.calc_fit = 1'b1;
                state_next   = S_GROW;
            end
            S_GROW: begin
                cmd.calc_grow = 1'b1;
                state_next    = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                // hand the word to the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    cmd.push     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Checks
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten while full");

    a_chk_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK_CHK) |-> $past(cmd.rd_issue))
        else $error("list entry checked without a fresh read");

endmodule

### hdl/ffa_datapath.sv
module ffa_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [ffa_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [ffa_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                               cfg_valid,
    input  logic [ffa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ffa_pkg::CFG_W-1:0]          cfg_data,
    input  ffa_pkg::cmd_t                      cmd,
    output ffa_pkg::sts_t                      sts,
    output logic [ffa_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [ffa_pkg::M_TUSER_W-1:0]      m_tuser
);
    import ffa_pkg::*;

    // Block stores
    logic [SIZE_W-1:0] size_mem [SLOT_COUNT];
    link_t             link_mem [SLOT_COUNT];
    logic [SIZE_W-1:0] size_rd_reg;
    link_t             link_rd_reg;

    // Request
    logic              op_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] addr_reg;

    // Allocator state
    logic [CFG_W-1:0]  heap_limit_reg, batch_bytes_reg;
    logic [SLOT_W-1:0] head_reg;
    logic              head_valid_reg;
    logic [CFG_W-1:0]  bump_reg, batch_end_reg;

    // Walk and bump working registers
    logic [SLOT_W-1:0] cur_reg, prev_reg;
    logic              have_prev_reg, cur_ok_reg;
    logic [STEP_W-1:0] steps_reg;
    logic [CFG_W-1:0]  need_reg, take_reg, start_reg;
    logic              fits_reg, over_reg;

    // Pending result and output register
    logic [ADDR_W-1:0] res_addr_reg, out_addr_reg;
    status_t           res_status_reg, out_status_reg;
    logic              res_reused_reg, out_reused_reg;

    logic [CFG_W-1:0]  limit_eff, rounded, need_next, take_next;
    logic              fits_next, over_next, oom;
    logic [ADDR_W-1:0] free_block, cur_addr;
    logic [SLOT_W-1:0] free_slot;
    logic              link_we, size_we;
    logic [SLOT_W-1:0] link_wa, size_wa;
    link_t             link_wd;

    // Bump arithmetic
    assign limit_eff = (heap_limit_reg > CFG_W'(HEAP_BYTES)) ? CFG_W'(HEAP_BYTES)
                                                             : heap_limit_reg;
    assign rounded   = ({1'b0, size_reg} + CFG_W'(ALIGN_BYTES - 1))
                       & ~CFG_W'(ALIGN_BYTES - 1);
    assign need_next = rounded + CFG_W'(HEADER_BYTES);
    assign fits_next = ({1'b0, bump_reg} + {1'b0, need_reg}) <= {1'b0, batch_end_reg};
    assign take_next = (need_reg > batch_bytes_reg) ? need_reg : batch_bytes_reg;
    assign over_next = ({1'b0, batch_end_reg} + {1'b0, take_reg}) > {1'b0, limit_eff};
    assign oom       = !fits_reg && over_reg;

    // Address to slot and back
    assign free_block = addr_reg - ADDR_W'(HEADER_BYTES);
    assign free_slot  = free_block[ADDR_W-1:ALIGN_SH];
    assign cur_addr   = {cur_reg, {ALIGN_SH{1'b0}}};

    // Store write ports
    assign size_we = cmd.commit && !oom;
    assign size_wa = start_reg[ADDR_W-1:ALIGN_SH];
    assign link_we = (cmd.unlink && have_prev_reg) || cmd.do_free;
    assign link_wa = cmd.do_free ? free_slot : prev_reg;
    always_comb begin
        if (cmd.do_free) begin
            link_wd.valid = head_valid_reg;
            link_wd.next  = head_reg;
        end else begin
            link_wd = link_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            size_rd_reg <= size_mem[cur_reg];
            link_rd_reg <= link_mem[cur_reg];
        end
        if (size_we) begin
            size_mem[size_wa] <= size_reg;
        end
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
    end

    // Status to controller
    assign sts.is_free    = (op_reg == OP_FREE);
    assign sts.size_zero  = (size_reg == '0);
    assign sts.addr_zero  = (addr_reg == '0);
    assign sts.cur_ok     = cur_ok_reg;
    assign sts.steps_done = (steps_reg == STEP_W'(SLOT_COUNT));
    assign sts.fit        = (size_rd_reg >= size_reg);

    // Allocator state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_limit_reg  <= HEAP_LIMIT_RST;
            batch_bytes_reg <= BATCH_RST;
            head_reg        <= '0;
            head_valid_reg  <= 1'b0;
            bump_reg        <= '0;
            batch_end_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_HEAP_LIMIT: heap_limit_reg  <= cfg_data;
                    CFG_BATCH:      batch_bytes_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.unlink && !have_prev_reg) begin
                head_reg       <= link_rd_reg.next;
                head_valid_reg <= link_rd_reg.valid;
            end
            if (cmd.do_free) begin
                head_reg       <= free_slot;
                head_valid_reg <= 1'b1;
            end
            if (cmd.commit && !oom) begin
                if (!fits_reg) begin
                    batch_end_reg <= batch_end_reg + take_reg;
                end
                bump_reg <= start_reg + need_reg;
            end
        end
    end

    // Request capture, walk, bump steps and results
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_tuser[0];
            size_reg <= s_tdata[SIZE_W-1:0];
            addr_reg <= s_tdata[SIZE_W +: ADDR_W];
        end
        if (cmd.walk_start) begin
            cur_reg       <= head_reg;
            cur_ok_reg    <= head_valid_reg;
            have_prev_reg <= 1'b0;
            steps_reg     <= '0;
        end
        if (cmd.walk_adv) begin
            prev_reg      <= cur_reg;
            have_prev_reg <= 1'b1;
            cur_reg       <= link_rd_reg.next;
            cur_ok_reg    <= link_rd_reg.valid;
            steps_reg     <= steps_reg + STEP_W'(1);
        end
        if (cmd.calc_need) begin
            need_reg <= need_next;
        end
        if (cmd.calc_fit) begin
            fits_reg <= fits_next;
            take_reg <= take_next;
        end
        if (cmd.calc_grow) begin
            over_reg  <= over_next;
            start_reg <= fits_reg ? bump_reg : batch_end_reg;
        end
        if (cmd.unlink) begin
            res_addr_reg   <= cur_addr + ADDR_W'(HEADER_BYTES);
            res_status_reg <= STAT_OK;
            res_reused_reg <= 1'b1;
        end
        if (cmd.commit) begin
            res_addr_reg   <= oom ? '0 : start_reg[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
            res_status_reg <= oom ? STAT_OOM : STAT_OK;
            res_reused_reg <= 1'b0;
        end
        if (cmd.do_free) begin
            res_addr_reg   <= '0;
            res_status_reg <= STAT_OK;
            res_reused_reg <= 1'b0;
        end
        if (cmd.res_zero) begin
            res_addr_reg   <= '0;
            res_status_reg <= STAT_ZERO_SIZE;
            res_reused_reg <= 1'b0;
        end
        if (cmd.res_null) begin
            res_addr_reg   <= '0;
            res_status_reg <= STAT_NULL_FREE;
            res_reused_reg <= 1'b0;
        end
        if (cmd.push) begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
            out_reused_reg <= res_reused_reg;
        end
    end

    assign m_tdata = out_addr_reg;
    assign m_tuser = {out_reused_reg, out_status_reg};

    // Checks
    a_bump_in_batch: assert property (@(posedge aclk) disable iff (!aresetn)
        bump_reg <= batch_end_reg)
        else $error("bump pointer past end of batch");

    a_break_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        batch_end_reg <= CFG_W'(HEAP_BYTES))
        else $error("break past end of heap");

    a_free_sets_head: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_free |=> head_valid_reg)
        else $error("list empty after a free");

    a_oom_keeps_bump: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && oom) |=> ($stable(bump_reg) && $stable(batch_end_reg)))
        else $error("failed batch moved the break");

endmodule

### hdl/first_fit_free_list_allocator.sv
// Flow: a free, a null free or a zero-size request is decoded and goes straight to the result;
// an allocation walks the free list and is served by the first entry whose stored size is large enough;
// if none fits, the allocation falls back to the bump path and its need, fit, grow and commit steps.
// One word in flight; the next word is taken once the result has entered the
// output register. The walk reads each entry into a register, then tests its size for a fit.
// Reset (aresetn low, synchronous) empties the list and zeroes the break; stores are not cleared.
module first_fit_free_list_allocator (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ffa_pkg::S_TDATA_W-1:0]      s_tdata,  // request_size, block_address
    input  logic [ffa_pkg::S_TUSER_W-1:0]      s_tuser,  // opcode
    // result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ffa_pkg::M_TDATA_W-1:0]      m_tdata,  // granted_address
    output logic [ffa_pkg::M_TUSER_W-1:0]      m_tuser,  // status, from_free_list
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ffa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ffa_pkg::CFG_W-1:0]          cfg_data
);
    import ffa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // registers are always writable
    assign cfg_ready = 1'b1;

    ffa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ffa_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
